// ===== hw/rtl/dhfk_pkg.sv =====
// ----------------------------------------------------------------------------
// dhfk_pkg
// Shared widths, payload types, reset words and rounding helpers for the
// Denavit-Hartenberg forward kinematics core.
// ----------------------------------------------------------------------------
package dhfk_pkg;

	localparam int NUM_JOINTS_DEF   = 6;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int MAX_JOINTS       = 6;

	localparam int ANGLE_W     = 16;
	localparam int THETA_W     = 17;
	localparam int DH_W        = 64;
	localparam int CFG_INDEX_W = 3;
	localparam int Q30_W       = 32;
	localparam int Z_W         = 24;
	localparam int TR_W        = 26;
	localparam int POS_W       = 32;
	localparam int ACT_W       = 48;
	localparam int PROD_W      = 66;
	localparam int MP_W        = 64;
	localparam int TP_W        = 58;
	localparam int ROT_W       = 16;
	localparam int OPOS_W      = 20;

	localparam int FULL_TURN    = 23040;
	localparam int HALF_TURN    = 11520;
	localparam int QUARTER_TURN = 5760;

	localparam logic signed [Q30_W-1:0] CORDIC_X0 = 32'sd652032874;
	localparam logic signed [Q30_W-1:0] Q30_ONE   = 32'sh4000_0000;

	localparam logic [MAX_JOINTS-1:0][DH_W-1:0] DH_RESET = {
		64'd20971520, 64'd256735965085696, 64'd24739129589760,
		64'd0, 64'd506654958079180800, 64'd24739043082240
	};

	typedef logic signed [Q30_W-1:0] q30_t;
	typedef logic signed [TR_W-1:0] tr_t;
	typedef logic [2:0][2:0][Q30_W-1:0] mat_t;
	typedef logic [2:0][POS_W-1:0] vec_t;

	typedef struct packed {
		mat_t                   a;
		logic [2:0][TR_W-1:0]   ta;
	} link_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] angle_one;
		logic signed [ANGLE_W-1:0] angle_two;
		logic signed [ANGLE_W-1:0] angle_three;
		logic signed [ANGLE_W-1:0] angle_four;
		logic signed [ANGLE_W-1:0] angle_five;
		logic signed [ANGLE_W-1:0] angle_six;
	} angles_t;

	typedef struct packed {
		logic signed [ROT_W-1:0]  rot_xx;
		logic signed [ROT_W-1:0]  rot_xy;
		logic signed [ROT_W-1:0]  rot_xz;
		logic signed [ROT_W-1:0]  rot_yx;
		logic signed [ROT_W-1:0]  rot_yy;
		logic signed [ROT_W-1:0]  rot_yz;
		logic signed [ROT_W-1:0]  rot_zx;
		logic signed [ROT_W-1:0]  rot_zy;
		logic signed [ROT_W-1:0]  rot_zz;
		logic signed [OPOS_W-1:0] pos_x;
		logic signed [OPOS_W-1:0] pos_y;
		logic signed [OPOS_W-1:0] pos_z;
	} pose_t;

	typedef struct packed {
		logic [CFG_INDEX_W-1:0] reg_index;
		logic [DH_W-1:0]        wdata;
	} cfg_req_t;

	localparam logic signed [PROD_W-1:0] RND30 = PROD_W'(1) <<< 29;
	localparam logic signed [ACT_W-1:0]  RND22 = ACT_W'(1) <<< 21;

	function automatic logic signed [Z_W-1:0] atan_val(input int i);
		logic signed [Z_W-1:0] v;
		case (i)
			0:       v = 24'sd737280;
			1:       v = 24'sd435242;
			2:       v = 24'sd229970;
			3:       v = 24'sd116736;
			4:       v = 24'sd58595;
			5:       v = 24'sd29326;
			6:       v = 24'sd14667;
			7:       v = 24'sd7334;
			8:       v = 24'sd3667;
			9:       v = 24'sd1833;
			10:      v = 24'sd917;
			11:      v = 24'sd458;
			12:      v = 24'sd229;
			13:      v = 24'sd115;
			14:      v = 24'sd57;
			15:      v = 24'sd29;
			16:      v = 24'sd14;
			17:      v = 24'sd7;
			18:      v = 24'sd4;
			19:      v = 24'sd2;
			20:      v = 24'sd1;
			default: v = 24'sd0;
		endcase
		return v;
	endfunction

	function automatic q30_t round30(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] s;
		s = (v + RND30) >>> 30;
		return q30_t'(s);
	endfunction

	function automatic tr_t round22(input logic signed [ACT_W-1:0] v);
		logic signed [ACT_W-1:0] s;
		s = (v + RND22) >>> 22;
		return tr_t'(s);
	endfunction

	function automatic mat_t ident();
		mat_t m;
		m = '0;
		m[0][0] = Q30_ONE;
		m[1][1] = Q30_ONE;
		m[2][2] = Q30_ONE;
		return m;
	endfunction

	localparam mat_t MAT_IDENT = ident();

endpackage

// ===== hw/rtl/dhfk_stream_if.sv =====
// ----------------------------------------------------------------------------
// dhfk_stream_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface dhfk_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/dh_forward_kinematics_core.sv =====
// ----------------------------------------------------------------------------
// dh_forward_kinematics_core
// Six-joint Denavit-Hartenberg forward kinematics, fully pipelined.
//
// angles (sink): one request holds six joint angles in 1/64 degree.
// pose (source): one result per request, the 3x3 rotation in Q2.14 and the
//   translation in quarter mm, saturated.
// cfg (sink): writes joint DH word reg_index (a, alpha, d, offset); indexes
//   at or above NUM_JOINTS are dropped. Always ready. Write only while idle.
// Throughput: one request per cycle while the output is not stalled. From
//   acceptance to pose.valid a request passes the wrap register, which loads
//   at the accepting edge, then one stage per CORDIC step, two link stages,
//   two per joint in the transform chain and the output register.
// Stall: a result waiting on pose parks in the output register and a skid
//   entry; the pipeline freezes only once both are full, losing nothing.
// Reset: clears all valids and loads the default arm's DH words.
// ----------------------------------------------------------------------------
module dh_forward_kinematics_core #(
	parameter int NUM_JOINTS   = dhfk_pkg::NUM_JOINTS_DEF,
	parameter int CORDIC_STEPS = dhfk_pkg::CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	dhfk_stream_if.sink   cfg,
	dhfk_stream_if.sink   angles,
	dhfk_stream_if.source pose
);
	import dhfk_pkg::*;

	logic [NUM_JOINTS-1:0][DH_W-1:0] dh_q;
	logic [MAX_JOINTS-1:0][ANGLE_W-1:0] ang;
	logic [2*NUM_JOINTS-1:0][THETA_W-1:0] theta;
	logic en;

	logic trig_v;
	logic [2*NUM_JOINTS-1:0][Q30_W-1:0] trig_x;
	logic [2*NUM_JOINTS-1:0][Q30_W-1:0] trig_y;
	logic [2*NUM_JOINTS-1:0] trig_neg;

	logic  v_c [NUM_JOINTS+1];
	mat_t  mat_c [NUM_JOINTS+1];
	vec_t  t_c [NUM_JOINTS+1];
	link_t [NUM_JOINTS-1:0] links_c [NUM_JOINTS+1];

	assign cfg.ready    = 1'b1;
	assign angles.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_JOINTS; i++) begin
				dh_q[i] <= DH_RESET[i];
			end
		end else if (cfg.valid && cfg.ready) begin
			for (int i = 0; i < NUM_JOINTS; i++) begin
				if (cfg.data.reg_index == CFG_INDEX_W'(i)) begin
					dh_q[i] <= cfg.data.wdata;
				end
			end
		end
	end

	assign ang[0] = angles.data.angle_one;
	assign ang[1] = angles.data.angle_two;
	assign ang[2] = angles.data.angle_three;
	assign ang[3] = angles.data.angle_four;
	assign ang[4] = angles.data.angle_five;
	assign ang[5] = angles.data.angle_six;

	// joint angle plus offset, then the twist angles
	always_comb begin
		for (int j = 0; j < NUM_JOINTS; j++) begin
			theta[j] = THETA_W'($signed(ang[j])) + THETA_W'($signed(dh_q[j][15:0]));
			theta[NUM_JOINTS+j] = THETA_W'($signed(dh_q[j][47:32]));
		end
	end

	dhfk_trig #(
		.LANES (2*NUM_JOINTS),
		.STEPS (CORDIC_STEPS)
	) u_trig (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (angles.valid && angles.ready),
		.theta   (theta),
		.v_out   (trig_v),
		.x_out   (trig_x),
		.y_out   (trig_y),
		.neg_out (trig_neg)
	);

	dhfk_link #(
		.NJ (NUM_JOINTS)
	) u_link (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (trig_v),
		.x_in   (trig_x),
		.y_in   (trig_y),
		.neg_in (trig_neg),
		.dh     (dh_q),
		.v_out  (v_c[0]),
		.links  (links_c[0])
	);

	assign mat_c[0] = MAT_IDENT;
	assign t_c[0]   = '0;

	for (genvar j = 0; j < NUM_JOINTS; j++) begin : g_chain
		dhfk_chain_stage #(
			.NJ    (NUM_JOINTS),
			.JOINT (j)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.v_in      (v_c[j]),
			.mat_in    (mat_c[j]),
			.t_in      (t_c[j]),
			.links_in  (links_c[j]),
			.v_out     (v_c[j+1]),
			.mat_out   (mat_c[j+1]),
			.t_out     (t_c[j+1]),
			.links_out (links_c[j+1])
		);
	end

	dhfk_output u_output (
		.clk    (clk),
		.arst_n (arst_n),
		.v_in   (v_c[NUM_JOINTS]),
		.mat_in (mat_c[NUM_JOINTS]),
		.t_in   (t_c[NUM_JOINTS]),
		.en     (en),
		.pose   (pose)
	);

	a_stall_only_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		!angles.ready |-> pose.valid)
		else $error("input stalled with no result pending");

	a_drain_reopens_input: assert property (@(posedge clk) disable iff (!arst_n)
		(pose.valid && pose.ready) |=> angles.ready)
		else $error("input still stalled after a result was taken");

	a_rot_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		pose.valid |-> (pose.data.rot_xx <= 16'sd16384) && (pose.data.rot_xx >= -16'sd16384))
		else $error("rotation output outside saturation range");

endmodule

// ===== hw/rtl/dhfk_trig.sv =====
// ----------------------------------------------------------------------------
// dhfk_trig
// Angle wrap and quadrant fold, then a pipelined rotation CORDIC with one
// step per stage, over all joint and twist angles in parallel.
// ----------------------------------------------------------------------------
module dhfk_trig #(
	parameter int LANES = 12,
	parameter int STEPS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic v_in,
	input  logic [LANES-1:0][dhfk_pkg::THETA_W-1:0] theta,
	output logic v_out,
	output logic [LANES-1:0][dhfk_pkg::Q30_W-1:0] x_out,
	output logic [LANES-1:0][dhfk_pkg::Q30_W-1:0] y_out,
	output logic [LANES-1:0] neg_out
);
	import dhfk_pkg::*;

	logic [STEPS:0] v_s;
	logic signed [Q30_W-1:0] x_s [STEPS+1][LANES];
	logic signed [Q30_W-1:0] y_s [STEPS+1][LANES];
	logic signed [Z_W-1:0]   z_s [STEPS+1][LANES];
	logic                    neg_s [STEPS+1][LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[STEPS-1:0], v_in};
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic signed [18:0] red;
		logic signed [18:0] fold;
		logic               neg;

		// wrap into [-180, 180) then fold into [-90, 90]
		always_comb begin
			red = 19'($signed(theta[l]));
			for (int k = -3; k <= 3; k++) begin
				if ((19'($signed(theta[l])) + 19'(k * FULL_TURN)) >= 19'sd0 - 19'(HALF_TURN)
						&& (19'($signed(theta[l])) + 19'(k * FULL_TURN)) < 19'(HALF_TURN)) begin
					red = 19'($signed(theta[l])) + 19'(k * FULL_TURN);
				end
			end
			fold = red;
			neg  = 1'b0;
			if (red > 19'(QUARTER_TURN)) begin
				fold = red - 19'(HALF_TURN);
				neg  = 1'b1;
			end else if (red < 19'sd0 - 19'(QUARTER_TURN)) begin
				fold = red + 19'(HALF_TURN);
				neg  = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[0][l]   <= CORDIC_X0;
				y_s[0][l]   <= '0;
				z_s[0][l]   <= Z_W'(fold) <<< 8;
				neg_s[0][l] <= neg;
			end
		end

		for (genvar i = 0; i < STEPS; i++) begin : g_step
			always_ff @(posedge clk) begin
				if (en) begin
					neg_s[i+1][l] <= neg_s[i][l];
					if (z_s[i][l] >= 0) begin
						x_s[i+1][l] <= x_s[i][l] - (y_s[i][l] >>> i);
						y_s[i+1][l] <= y_s[i][l] + (x_s[i][l] >>> i);
						z_s[i+1][l] <= z_s[i][l] - atan_val(i);
					end else begin
						x_s[i+1][l] <= x_s[i][l] + (y_s[i][l] >>> i);
						y_s[i+1][l] <= y_s[i][l] - (x_s[i][l] >>> i);
						z_s[i+1][l] <= z_s[i][l] + atan_val(i);
					end
				end
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			x_out[l]   = x_s[STEPS][l];
			y_out[l]   = y_s[STEPS][l];
			neg_out[l] = neg_s[STEPS][l];
		end
	end

	assign v_out = v_s[STEPS];

endmodule

// ===== hw/rtl/dhfk_link.sv =====
// ----------------------------------------------------------------------------
// dhfk_link
// Builds each joint's rotation and translation from the CORDIC outputs and
// the link length and offset: one multiply stage, one rounding stage.
// ----------------------------------------------------------------------------
module dhfk_link #(
	parameter int NJ = 6
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic v_in,
	input  logic [2*NJ-1:0][dhfk_pkg::Q30_W-1:0] x_in,
	input  logic [2*NJ-1:0][dhfk_pkg::Q30_W-1:0] y_in,
	input  logic [2*NJ-1:0] neg_in,
	input  logic [NJ-1:0][dhfk_pkg::DH_W-1:0] dh,
	output logic v_out,
	output dhfk_pkg::link_t [NJ-1:0] links
);
	import dhfk_pkg::*;

	logic  v_s1;
	logic  v_s2;
	link_t lk_s2 [NJ];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
		end
	end

	for (genvar j = 0; j < NJ; j++) begin : g_joint
		logic signed [Q30_W-1:0] ct, st, ca, sa;
		logic signed [ANGLE_W-1:0] a_len;
		logic signed [Q30_W-1:0] ct_s1, st_s1, ca_s1, sa_s1;
		logic signed [MP_W-1:0]  sc_s1, ss_s1, cc_s1, cs_s1;
		logic signed [ACT_W-1:0] act_s1, ast_s1;
		logic signed [ANGLE_W-1:0] d_s1;

		assign ct    = neg_in[j] ? -$signed(x_in[j]) : $signed(x_in[j]);
		assign st    = neg_in[j] ? -$signed(y_in[j]) : $signed(y_in[j]);
		assign ca    = neg_in[NJ+j] ? -$signed(x_in[NJ+j]) : $signed(x_in[NJ+j]);
		assign sa    = neg_in[NJ+j] ? -$signed(y_in[NJ+j]) : $signed(y_in[NJ+j]);
		assign a_len = $signed(dh[j][63:48]);

		always_ff @(posedge clk) begin
			if (en) begin
				ct_s1  <= ct;
				st_s1  <= st;
				ca_s1  <= ca;
				sa_s1  <= sa;
				sc_s1  <= st * ca;
				ss_s1  <= st * sa;
				cc_s1  <= ct * ca;
				cs_s1  <= ct * sa;
				act_s1 <= a_len * ct;
				ast_s1 <= a_len * st;
				d_s1   <= $signed(dh[j][31:16]);
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				lk_s2[j].a[0][0] <= ct_s1;
				lk_s2[j].a[0][1] <= -round30(PROD_W'(sc_s1));
				lk_s2[j].a[0][2] <= round30(PROD_W'(ss_s1));
				lk_s2[j].a[1][0] <= st_s1;
				lk_s2[j].a[1][1] <= round30(PROD_W'(cc_s1));
				lk_s2[j].a[1][2] <= -round30(PROD_W'(cs_s1));
				lk_s2[j].a[2][0] <= '0;
				lk_s2[j].a[2][1] <= sa_s1;
				lk_s2[j].a[2][2] <= ca_s1;
				lk_s2[j].ta[0]   <= round22(act_s1);
				lk_s2[j].ta[1]   <= round22(ast_s1);
				lk_s2[j].ta[2]   <= TR_W'(d_s1) <<< 8;
			end
		end
	end

	always_comb begin
		for (int j = 0; j < NJ; j++) begin
			links[j] = lk_s2[j];
		end
	end

	assign v_out = v_s2;

endmodule

// ===== hw/rtl/dhfk_chain_stage.sv =====
// ----------------------------------------------------------------------------
// dhfk_chain_stage
// Multiplies the running pose by one joint's transform: products in the
// first stage, sums and rounding in the second.
// ----------------------------------------------------------------------------
module dhfk_chain_stage #(
	parameter int NJ    = 6,
	parameter int JOINT = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic v_in,
	input  dhfk_pkg::mat_t mat_in,
	input  dhfk_pkg::vec_t t_in,
	input  dhfk_pkg::link_t [NJ-1:0] links_in,
	output logic v_out,
	output dhfk_pkg::mat_t mat_out,
	output dhfk_pkg::vec_t t_out,
	output dhfk_pkg::link_t [NJ-1:0] links_out
);
	import dhfk_pkg::*;

	link_t lk;
	logic  v_s1;
	logic  v_s2;
	logic signed [MP_W-1:0]  pm_s1 [3][3][3];
	logic signed [TP_W-1:0]  pt_s1 [3][3];
	logic signed [POS_W-1:0] t_s1 [3];
	link_t [NJ-1:0] links_s1;
	link_t [NJ-1:0] links_s2;
	mat_t  n_mat;
	vec_t  n_t;
	mat_t  mat_s2;
	vec_t  t_s2;

	assign lk = links_in[JOINT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					for (int i = 0; i < 3; i++) begin
						pm_s1[r][k][i] <= $signed(mat_in[r][i]) * $signed(lk.a[i][k]);
					end
					pt_s1[r][k] <= $signed(mat_in[r][k]) * $signed(lk.ta[k]);
				end
				t_s1[r] <= $signed(t_in[r]);
			end
			links_s1 <= links_in;
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				n_mat[r][k] = round30(PROD_W'(pm_s1[r][k][0]) + PROD_W'(pm_s1[r][k][1])
					+ PROD_W'(pm_s1[r][k][2]));
			end
			n_t[r] = t_s1[r] + round30(PROD_W'(pt_s1[r][0]) + PROD_W'(pt_s1[r][1])
				+ PROD_W'(pt_s1[r][2]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mat_s2   <= n_mat;
			t_s2     <= n_t;
			links_s2 <= links_s1;
		end
	end

	assign v_out     = v_s2;
	assign mat_out   = mat_s2;
	assign t_out     = t_s2;
	assign links_out = links_s2;

endmodule

// ===== hw/rtl/dhfk_output.sv =====
// ----------------------------------------------------------------------------
// dhfk_output
// Rounds and saturates the final pose into the result format and holds it
// in an output register backed by a one-entry skid buffer.
// ----------------------------------------------------------------------------
module dhfk_output (
	input  logic clk,
	input  logic arst_n,
	input  logic v_in,
	input  dhfk_pkg::mat_t mat_in,
	input  dhfk_pkg::vec_t t_in,
	output logic en,
	dhfk_stream_if.source pose
);
	import dhfk_pkg::*;

	pose_t res;
	pose_t out_q;
	pose_t skid_q;
	logic  out_v_q;
	logic  skid_v_q;
	logic  push;

	function automatic logic signed [ROT_W-1:0] sat_rot(input logic [Q30_W-1:0] v);
		logic signed [Q30_W:0] r;
		r = ((Q30_W+1)'($signed(v)) + 33'sd32768) >>> 16;
		if (r > 33'sd16384) begin
			r = 33'sd16384;
		end else if (r < -33'sd16384) begin
			r = -33'sd16384;
		end
		return ROT_W'(r);
	endfunction

	function automatic logic signed [OPOS_W-1:0] sat_pos(input logic [POS_W-1:0] v);
		logic signed [POS_W:0] r;
		r = ((POS_W+1)'($signed(v)) + 33'sd128) >>> 8;
		if (r > 33'sd524287) begin
			r = 33'sd524287;
		end else if (r < -33'sd524288) begin
			r = -33'sd524288;
		end
		return OPOS_W'(r);
	endfunction

	always_comb begin
		res.rot_xx = sat_rot(mat_in[0][0]);
		res.rot_xy = sat_rot(mat_in[0][1]);
		res.rot_xz = sat_rot(mat_in[0][2]);
		res.rot_yx = sat_rot(mat_in[1][0]);
		res.rot_yy = sat_rot(mat_in[1][1]);
		res.rot_yz = sat_rot(mat_in[1][2]);
		res.rot_zx = sat_rot(mat_in[2][0]);
		res.rot_zy = sat_rot(mat_in[2][1]);
		res.rot_zz = sat_rot(mat_in[2][2]);
		res.pos_x  = sat_pos(t_in[0]);
		res.pos_y  = sat_pos(t_in[1]);
		res.pos_z  = sat_pos(t_in[2]);
	end

	assign en   = !skid_v_q;
	assign push = v_in && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || pose.ready) begin
			out_v_q  <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || pose.ready) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign pose.valid = out_v_q;
	assign pose.data  = out_q;

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Checks the six-joint forward kinematics core. Every joint-angle request is
// predicted from a local copy of the DH words; each pose result is compared
// field by field against the oldest prediction. Directed extremes come first,
// then random requests under several DH settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_top;
	import dhfk_pkg::*;

	localparam int DRAIN_CYCLES = 2 * NUM_JOINTS_DEF + CORDIC_STEPS_DEF + 12;
	localparam int WATCHDOG_MAX = 5000;
	localparam int NUM_REGS     = 6;

	logic clk;
	logic arst_n;

	dhfk_stream_if #(.T(cfg_req_t)) cfg_if ();
	dhfk_stream_if #(.T(angles_t))  ang_if ();
	dhfk_stream_if #(.T(pose_t))    pose_if ();

	dh_forward_kinematics_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if.sink),
		.angles (ang_if.sink),
		.pose   (pose_if.source)
	);

	logic [DH_W-1:0] dh_model [NUM_REGS];
	pose_t           pose_queue [$];
	int              error_count;
	int              req_count;
	int              pose_count;
	int              cfg_count;
	int              idle_pct;
	int              stall_pct;
	int              quiet_cycles;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic longint sx16(input logic [15:0] v);
		return longint'($signed(v));
	endfunction

	function automatic longint rnd_shift(input longint v, input int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic void sin_cos(input longint theta, output longint c, output longint s);
		longint r, x, y, z, xs, ys;
		bit     neg;
		r   = theta % FULL_TURN;
		neg = 1'b0;
		if (r >= HALF_TURN) r -= FULL_TURN;
		if (r < -HALF_TURN) r += FULL_TURN;
		if (r > QUARTER_TURN) begin
			r -= HALF_TURN;
			neg = 1'b1;
		end else if (r < -QUARTER_TURN) begin
			r += HALF_TURN;
			neg = 1'b1;
		end
		x = 652032874;
		y = 0;
		z = r * 256;
		for (int i = 0; i < CORDIC_STEPS_DEF && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys;
				y += xs;
				z -= longint'(atan_val(i));
			end else begin
				x += ys;
				y -= xs;
				z += longint'(atan_val(i));
			end
		end
		c = neg ? -x : x;
		s = neg ? -y : y;
	endfunction

	function automatic longint qmul(input longint p, input longint q);
		return rnd_shift(p * q, 30);
	endfunction

	function automatic pose_t predict_pose(input angles_t ang);
		longint rm [3][3];
		longint nm [3][3];
		longint am [3][3];
		longint ta [3];
		longint tv [3];
		longint jang [6];
		longint a, al, d, off, ct, st, ca, sa, acc;
		logic [DH_W-1:0] w;
		pose_t p;
		jang = '{sx16(ang.angle_one), sx16(ang.angle_two), sx16(ang.angle_three),
			sx16(ang.angle_four), sx16(ang.angle_five), sx16(ang.angle_six)};
		for (int r = 0; r < 3; r++) begin
			tv[r] = 0;
			for (int k = 0; k < 3; k++) rm[r][k] = (r == k) ? (longint'(1) << 30) : 0;
		end
		for (int j = 0; j < NUM_JOINTS_DEF; j++) begin
			w   = dh_model[j];
			a   = sx16(w[63:48]);
			al  = sx16(w[47:32]);
			d   = sx16(w[31:16]);
			off = sx16(w[15:0]);
			sin_cos(jang[j] + off, ct, st);
			sin_cos(al, ca, sa);
			am[0][0] = ct; am[0][1] = -qmul(st, ca); am[0][2] = qmul(st, sa);
			am[1][0] = st; am[1][1] = qmul(ct, ca);  am[1][2] = -qmul(ct, sa);
			am[2][0] = 0;  am[2][1] = sa;            am[2][2] = ca;
			ta[0] = rnd_shift(a * ct, 22);
			ta[1] = rnd_shift(a * st, 22);
			ta[2] = d * 256;
			for (int r = 0; r < 3; r++) begin
				acc = 0;
				for (int k = 0; k < 3; k++) begin
					nm[r][k] = rnd_shift(rm[r][0] * am[0][k] + rm[r][1] * am[1][k]
						+ rm[r][2] * am[2][k], 30);
					acc += rm[r][k] * ta[k];
				end
				tv[r] += rnd_shift(acc, 30);
			end
			rm = nm;
		end
		p.rot_xx = ROT_W'(clip(rnd_shift(rm[0][0], 16), -16384, 16384));
		p.rot_xy = ROT_W'(clip(rnd_shift(rm[0][1], 16), -16384, 16384));
		p.rot_xz = ROT_W'(clip(rnd_shift(rm[0][2], 16), -16384, 16384));
		p.rot_yx = ROT_W'(clip(rnd_shift(rm[1][0], 16), -16384, 16384));
		p.rot_yy = ROT_W'(clip(rnd_shift(rm[1][1], 16), -16384, 16384));
		p.rot_yz = ROT_W'(clip(rnd_shift(rm[1][2], 16), -16384, 16384));
		p.rot_zx = ROT_W'(clip(rnd_shift(rm[2][0], 16), -16384, 16384));
		p.rot_zy = ROT_W'(clip(rnd_shift(rm[2][1], 16), -16384, 16384));
		p.rot_zz = ROT_W'(clip(rnd_shift(rm[2][2], 16), -16384, 16384));
		p.pos_x  = OPOS_W'(clip(rnd_shift(tv[0], 8), -524288, 524287));
		p.pos_y  = OPOS_W'(clip(rnd_shift(tv[1], 8), -524288, 524287));
		p.pos_z  = OPOS_W'(clip(rnd_shift(tv[2], 8), -524288, 524287));
		return p;
	endfunction

	function automatic void check_field(input string fname, input longint exp_v,
		input longint act_v);
		if (exp_v != act_v) begin
			$error("pose %0d field %s: expected %0d, got %0d", pose_count, fname,
				exp_v, act_v);
			error_count++;
		end
	endfunction

	// monitors: requests, config writes, results and a handshake watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (ang_if.valid && ang_if.ready) begin
				pose_queue.insert(pose_queue.size(), predict_pose(ang_if.data));
				req_count++;
			end
			if (cfg_if.valid && cfg_if.ready) begin
				if (cfg_if.data.reg_index < NUM_REGS)
					dh_model[cfg_if.data.reg_index] = cfg_if.data.wdata;
				cfg_count++;
			end
			if (pose_if.valid && pose_if.ready) begin
				pose_t e;
				pose_t g;
				g = pose_if.data;
				if (pose_queue.size() == 0) begin
					$error("pose result with no request outstanding");
					error_count++;
				end else begin
					e = pose_queue.pop_front();
					check_field("rot_xx", e.rot_xx, g.rot_xx);
					check_field("rot_xy", e.rot_xy, g.rot_xy);
					check_field("rot_xz", e.rot_xz, g.rot_xz);
					check_field("rot_yx", e.rot_yx, g.rot_yx);
					check_field("rot_yy", e.rot_yy, g.rot_yy);
					check_field("rot_yz", e.rot_yz, g.rot_yz);
					check_field("rot_zx", e.rot_zx, g.rot_zx);
					check_field("rot_zy", e.rot_zy, g.rot_zy);
					check_field("rot_zz", e.rot_zz, g.rot_zz);
					check_field("pos_x", e.pos_x, g.pos_x);
					check_field("pos_y", e.pos_y, g.pos_y);
					check_field("pos_z", e.pos_z, g.pos_z);
				end
				pose_count++;
			end
			if ((ang_if.valid && ang_if.ready) || (cfg_if.valid && cfg_if.ready)
				|| (pose_if.valid && pose_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_MAX) begin
				$display("watchdog: no handshake for %0d cycles", WATCHDOG_MAX);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		pose_if.ready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic send_angles(input angles_t ang);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			ang_if.valid <= 1'b0;
			@(negedge clk);
		end
		ang_if.valid <= 1'b1;
		ang_if.data  <= ang;
		do @(posedge clk); while (!ang_if.ready);
	endtask

	task automatic release_angles();
		@(negedge clk);
		ang_if.valid <= 1'b0;
	endtask

	task automatic wait_drain();
		while (pose_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_dh(input int idx, input logic [DH_W-1:0] value);
		@(negedge clk);
		cfg_if.valid          <= 1'b1;
		cfg_if.data.reg_index <= CFG_INDEX_W'(idx);
		cfg_if.data.wdata     <= value;
		do @(posedge clk); while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	function automatic angles_t uniform_angles(input logic [15:0] v);
		angles_t a;
		a = {6{v}};
		return a;
	endfunction

	function automatic logic [15:0] rand_angle();
		if ($urandom_range(9) == 0) return 16'($urandom);
		return 16'($signed($urandom_range(46080)) - 23040);
	endfunction

	function automatic angles_t rand_angles();
		angles_t a;
		a.angle_one   = rand_angle();
		a.angle_two   = rand_angle();
		a.angle_three = rand_angle();
		a.angle_four  = rand_angle();
		a.angle_five  = rand_angle();
		a.angle_six   = rand_angle();
		return a;
	endfunction

	function automatic logic [15:0] rand_dh_field();
		case ($urandom_range(4))
			0:       return 16'h7fff;
			1:       return 16'h8000;
			2:       return 16'($signed($urandom_range(2000)) - 1000);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic load_random_arm();
		for (int i = 0; i < NUM_REGS; i++)
			write_dh(i, {rand_dh_field(), rand_dh_field(), rand_dh_field(), rand_dh_field()});
	endtask

	task automatic test_default_arm();
		logic [15:0] edge_vals [12];
		edge_vals = '{16'sd0, 16'sd23040, -16'sd23040, 16'sd5760, -16'sd5760, 16'sd11520,
			-16'sd11520, 16'sd5761, -16'sd5761, 16'h7fff, 16'h8000, 16'sd1};
		idle_pct  = 0;
		stall_pct = 0;
		foreach (edge_vals[i]) send_angles(uniform_angles(edge_vals[i]));
		for (int i = 0; i < 4; i++) send_angles(rand_angles());
		release_angles();
		wait_drain();
	endtask

	task automatic test_dh_extremes();
		logic [DH_W-1:0] words [3];
		words = '{64'd0, {64{1'b1}}, {16'h7fff, 16'h8000, 16'h7fff, 16'h8000}};
		foreach (words[w]) begin
			for (int i = 0; i < NUM_REGS; i++) write_dh(i, words[w]);
			send_angles(uniform_angles(16'sd0));
			send_angles(uniform_angles(16'h7fff));
			send_angles(rand_angles());
			release_angles();
			wait_drain();
		end
		// out-of-range register indexes must leave the arm untouched
		write_dh(6, {64{1'b1}});
		write_dh(7, 64'h1234_5678_9abc_def0);
		send_angles(uniform_angles(16'sd1000));
		release_angles();
		wait_drain();
	endtask

	task automatic test_random_phase(input int idle_p, input int stall_p, input int n,
		input bit hold_mid);
		load_random_arm();
		idle_pct  = idle_p;
		stall_pct = stall_p;
		for (int i = 0; i < n; i++) begin
			send_angles(rand_angles());
			if (hold_mid && i == n / 2) begin
				release_angles();
				while (pose_queue.size() != 0) @(posedge clk);
			end
		end
		release_angles();
		wait_drain();
		idle_pct  = 0;
		stall_pct = 0;
	endtask

	initial begin
		arst_n        = 1'b0;
		error_count   = 0;
		req_count     = 0;
		pose_count    = 0;
		cfg_count     = 0;
		quiet_cycles  = 0;
		idle_pct      = 0;
		stall_pct     = 0;
		ang_if.valid  = 1'b0;
		ang_if.data   = '0;
		cfg_if.valid  = 1'b0;
		cfg_if.data   = '0;
		pose_if.ready = 1'b0;
		for (int i = 0; i < NUM_REGS; i++) dh_model[i] = DH_RESET[i];
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_default_arm();
		test_dh_extremes();
		test_random_phase(0, 0, 270, 1'b0);
		test_random_phase(70, 0, 270, 1'b1);
		test_random_phase(0, 70, 270, 1'b0);
		test_random_phase(33, 33, 270, 1'b0);
		test_random_phase(0, 0, 250, 1'b0);

		$display("covered %0d angle requests, %0d poses, %0d DH writes", req_count,
			pose_count, cfg_count);
		$display("DH settings: reset arm, all-zero, all-ones, extremes, five random arms");
		if (error_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
